// ----- rtl/lrl_pkg.sv -----
package lrl_pkg;

    // Default sizes
    localparam int MAX_IN_DEF   = 64;
    localparam int MAX_OUT_DEF  = 64;
    localparam int MAX_RANK_DEF = 16;

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int IDX_W      = 6;
    localparam int VAL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int ACC_W  = 40;
    localparam int RQ_W   = 24;
    localparam int MUL_AW = 25;
    localparam int MUL_BW = 17;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int SPLIT  = 22;

    // Item function codes
    localparam logic [FUNC_W-1:0] FN_LOAD_W    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_BIAS = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD_A    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOAD_B    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FEATURE   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_DIM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANK        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTER_EN  = 3'd7;

    // MAC pipeline operations
    localparam int OP_W_BITS = 3;
    localparam logic [OP_W_BITS-1:0] OP_W   = 3'd0;
    localparam logic [OP_W_BITS-1:0] OP_A   = 3'd1;
    localparam logic [OP_W_BITS-1:0] OP_B   = 3'd2;
    localparam logic [OP_W_BITS-1:0] OP_SLO = 3'd3;
    localparam logic [OP_W_BITS-1:0] OP_SHI = 3'd4;

    // Control of one accumulator chain
    typedef struct packed {
        logic shift;
        logic clr;
    } chain_ctl_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Saturate a grown sum to the accumulator range
    function automatic logic [ACC_W-1:0] sat_acc(input logic signed [ACC_W+2:0] s);
        logic [ACC_W-1:0] r;
        if (s[ACC_W+2:ACC_W-1] == 4'b0000 || s[ACC_W+2:ACC_W-1] == 4'b1111)
        begin
            r = s[ACC_W-1:0];
        end
        else if (s[ACC_W+2])
        begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- rtl/lrl_if.sv -----
interface lrl_item_if;
    import lrl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    modport source (output valid, func, row, col, value, last, input ready);
    modport sink   (input valid, func, row, col, value, last, output ready);
endinterface

interface lrl_result_if;
    import lrl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    saturated;
    logic                    out_last;
    modport source (output valid, out_index, out_value, saturated, out_last, input ready);
    modport sink   (input valid, out_index, out_value, saturated, out_last, output ready);
endinterface

interface lrl_cfg_if;
    import lrl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/lora_linear_forward.sv -----
// Low-rank adapted linear layer, signed Q8.8.
// Channels: item (sink) takes loads of W, bias, A, B and feature elements;
// result (source) gives one beat per output column; cfg (sink) writes the
// eight registers by index and is always ready.
// A load is written to its memory as it is taken. A feature element walks
// the output accumulator chain and the rank accumulator chain through one
// shared multiplier. On the last element each column is then emitted after a
// B row walk, two partial products for the scale and the final rounding.
// Items are taken only between elements; results sit in an output register,
// and a stalled receiver holds the column sequencer in place.
// Reset clears the accumulator chains and control state and presets the
// configuration registers; weight memories are undefined until loaded.
module lora_linear_forward
    import lrl_pkg::*;
#(
    parameter int MAX_IN   = MAX_IN_DEF,
    parameter int MAX_OUT  = MAX_OUT_DEF,
    parameter int MAX_RANK = MAX_RANK_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    lrl_item_if.sink     item,
    lrl_result_if.source result,
    lrl_cfg_if.sink      cfg
);

    localparam int WD   = MAX_IN * MAX_OUT;
    localparam int AD   = MAX_IN * MAX_RANK;
    localparam int BD   = MAX_RANK * MAX_OUT;
    localparam int WAW  = addr_bits(WD);
    localparam int AAW  = addr_bits(AD);
    localparam int BAW  = addr_bits(BD);
    localparam int CAW  = addr_bits(MAX_OUT);
    localparam int KW   = addr_bits(MAX_OUT + MAX_RANK);
    localparam int OCW  = $clog2(MAX_OUT + 1);
    localparam int RCW  = $clog2(MAX_RANK + 1);
    localparam int SUMW = RQ_W + VAL_W + $clog2(MAX_RANK) + 1;
    localparam int ADPW = SUMW + MUL_BW + 1;
    localparam int TOTW = ADPW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FEAT  = 4'd1;
    localparam logic [3:0] S_FWAIT = 4'd2;
    localparam logic [3:0] S_CBEG  = 4'd3;
    localparam logic [3:0] S_BISS  = 4'd4;
    localparam logic [3:0] S_BWAIT = 4'd5;
    localparam logic [3:0] S_SLO   = 4'd6;
    localparam logic [3:0] S_SHI   = 4'd7;
    localparam logic [3:0] S_SWAIT = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    // Configuration registers
    logic [6:0]  in_dim_reg, out_dim_reg, slice_width_reg;
    logic [4:0]  rank_reg;
    logic [15:0] scale_reg;
    logic [5:0]  slice_start_reg;
    logic        bias_en_reg, adapter_en_reg;

    // Control
    logic [3:0]     state_reg, state_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [OCW-1:0] o_reg, o_next;
    logic [RCW-1:0] b_reg, b_next;
    logic           last_reg, rowok_reg, colact_reg;
    logic           s1_valid_reg, s1_en_reg, s2_valid_reg;
    logic [OP_W_BITS-1:0] s1_op_reg, s2_op_reg;

    // Payload
    logic signed [VAL_W-1:0]  x_reg;
    logic [IDX_W-1:0]         row_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUMW-1:0]   sum_reg;
    logic signed [ADPW-1:0]   adp_reg;
    logic signed [TOTW-1:0]   total_reg;

    // Result register
    logic                    res_valid_reg;
    logic [IDX_W-1:0]        res_index_reg;
    logic signed [VAL_W-1:0] res_value_reg;
    logic                    res_sat_reg, res_last_reg;

    logic [OCW-1:0] nout;
    logic [RCW-1:0] nrank;
    logic           item_fire, busy, emit_fire, done_fire, colact_now;
    logic           iss_valid, iss_en;
    logic [OP_W_BITS-1:0] iss_op;

    logic           w_rd_en, a_rd_en, b_rd_en, bias_rd_en;
    logic           w_wr_en, a_wr_en, b_wr_en, bias_wr_en;
    logic [WAW-1:0] w_rd_addr, w_wr_addr;
    logic [AAW-1:0] a_rd_addr, a_wr_addr;
    logic [BAW-1:0] b_rd_addr, b_wr_addr;
    logic [CAW-1:0] bias_rd_addr, bias_wr_addr;
    logic [VAL_W-1:0] w_rdata, a_rdata, b_rdata, bias_rdata;

    logic signed [MUL_AW-1:0] mult_a;
    logic signed [MUL_BW-1:0] mult_b;
    logic signed [PROD_W-1:0] mult_p;
    logic signed [RQ_W-1:0]   rq;
    logic signed [ACC_W:0]    rq_wide;
    logic signed [ACC_W-8:0]  rq_shift;

    chain_ctl_t       out_ctl, rank_ctl;
    logic [ACC_W-1:0] out_head, out_tail, rank_head, rank_tail;
    logic [ACC_W-1:0] out_upd, rank_upd;

    logic signed [ADPW-1:0]  adp_round;
    logic signed [TOTW-1:0]  total_sum;
    logic signed [TOTW-1:0]  y_wide;
    logic signed [VAL_W-1:0] y_sat;
    logic                    y_clip;

    // Effective counts
    always_comb
    begin
        nout  = (32'(out_dim_reg) > MAX_OUT) ? OCW'(MAX_OUT) : OCW'(out_dim_reg);
        nrank = (32'(rank_reg) > MAX_RANK) ? RCW'(MAX_RANK) : RCW'(rank_reg);
    end

    assign item.ready = (state_reg == S_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign busy       = s1_valid_reg || s2_valid_reg;
    assign emit_fire  = (state_reg == S_EMIT) && (!res_valid_reg || result.ready);
    assign done_fire  = emit_fire && (32'(o_reg) + 1 == 32'(nout));

    assign colact_now = adapter_en_reg && (32'(o_reg) >= 32'(slice_start_reg))
                        && (32'(o_reg) - 32'(slice_start_reg) < 32'(slice_width_reg));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_dim_reg      <= 7'd64;
            out_dim_reg     <= 7'd64;
            rank_reg        <= 5'd16;
            scale_reg       <= 16'd256;
            slice_start_reg <= 6'd0;
            slice_width_reg <= 7'd64;
            bias_en_reg     <= 1'b0;
            adapter_en_reg  <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_IN_DIM:      in_dim_reg      <= cfg.data[6:0];
                REG_OUT_DIM:     out_dim_reg     <= cfg.data[6:0];
                REG_RANK:        rank_reg        <= cfg.data[4:0];
                REG_SCALE:       scale_reg       <= cfg.data;
                REG_SLICE_START: slice_start_reg <= cfg.data[5:0];
                REG_SLICE_WIDTH: slice_width_reg <= cfg.data[6:0];
                REG_BIAS_EN:     bias_en_reg     <= cfg.data[0];
                REG_ADAPTER_EN:  adapter_en_reg  <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // Load writes
    always_comb
    begin
        w_wr_en    = item_fire && item.func == FN_LOAD_W
                     && 32'(item.row) < MAX_IN && 32'(item.col) < MAX_OUT;
        bias_wr_en = item_fire && item.func == FN_LOAD_BIAS && 32'(item.col) < MAX_OUT;
        a_wr_en    = item_fire && item.func == FN_LOAD_A
                     && 32'(item.row) < MAX_IN && 32'(item.col) < MAX_RANK;
        b_wr_en    = item_fire && item.func == FN_LOAD_B
                     && 32'(item.row) < MAX_RANK && 32'(item.col) < MAX_OUT;
        w_wr_addr    = WAW'(32'(item.row) * MAX_OUT + 32'(item.col));
        a_wr_addr    = AAW'(32'(item.row) * MAX_RANK + 32'(item.col));
        b_wr_addr    = BAW'(32'(item.row) * MAX_OUT + 32'(item.col));
        bias_wr_addr = CAW'(item.col);
    end

    // Issue of MAC operations
    always_comb
    begin
        iss_valid  = 1'b0;
        iss_en     = 1'b0;
        iss_op     = OP_W;
        w_rd_en    = 1'b0;
        a_rd_en    = 1'b0;
        b_rd_en    = 1'b0;
        bias_rd_en = 1'b0;
        w_rd_addr  = WAW'(32'(row_reg) * MAX_OUT + 32'(k_reg));
        a_rd_addr  = AAW'(32'(row_reg) * MAX_RANK + 32'(k_reg) - MAX_OUT);
        b_rd_addr  = BAW'(32'(b_reg) * MAX_OUT + 32'(o_reg) - 32'(slice_start_reg));
        bias_rd_addr = CAW'(o_reg);
        case (state_reg)
            S_FEAT:
            begin
                iss_valid = 1'b1;
                if (32'(k_reg) < MAX_OUT)
                begin
                    iss_op  = OP_W;
                    iss_en  = rowok_reg && (32'(k_reg) < 32'(nout));
                    w_rd_en = 1'b1;
                end
                else
                begin
                    iss_op  = OP_A;
                    iss_en  = rowok_reg && (32'(k_reg) - MAX_OUT < 32'(nrank));
                    a_rd_en = 1'b1;
                end
            end
            S_CBEG:
            begin
                bias_rd_en = 1'b1;
            end
            S_BISS:
            begin
                iss_valid = 1'b1;
                iss_op    = OP_B;
                iss_en    = colact_reg && (b_reg < nrank);
                b_rd_en   = 1'b1;
            end
            S_SLO:
            begin
                iss_valid = 1'b1;
                iss_op    = OP_SLO;
                iss_en    = 1'b1;
            end
            S_SHI:
            begin
                iss_valid = 1'b1;
                iss_op    = OP_SHI;
                iss_en    = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        o_next     = o_reg;
        b_next     = b_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_fire && item.func == FN_FEATURE)
                begin
                    state_next = S_FEAT;
                    k_next     = '0;
                end
            end
            S_FEAT:
            begin
                k_next = k_reg + 1'b1;
                if (32'(k_reg) == MAX_OUT + MAX_RANK - 1)
                begin
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                if (!busy)
                begin
                    o_next = '0;
                    if (!last_reg || nout == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_CBEG;
                    end
                end
            end
            S_CBEG:
            begin
                b_next     = '0;
                state_next = S_BISS;
            end
            S_BISS:
            begin
                b_next = b_reg + 1'b1;
                if (32'(b_reg) == MAX_RANK - 1)
                begin
                    state_next = S_BWAIT;
                end
            end
            S_BWAIT:
            begin
                if (!busy)
                begin
                    state_next = S_SLO;
                end
            end
            S_SLO:   state_next = S_SHI;
            S_SHI:   state_next = S_SWAIT;
            S_SWAIT:
            begin
                if (!busy)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    o_next     = o_reg + 1'b1;
                    state_next = done_fire ? S_IDLE : S_CBEG;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            o_reg        <= '0;
            b_reg        <= '0;
            last_reg     <= 1'b0;
            rowok_reg    <= 1'b0;
            colact_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_en_reg    <= 1'b0;
            s1_op_reg    <= OP_W;
            s2_valid_reg <= 1'b0;
            s2_op_reg    <= OP_W;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            o_reg        <= o_next;
            b_reg        <= b_next;
            s1_valid_reg <= iss_valid;
            s1_en_reg    <= iss_en;
            s1_op_reg    <= iss_op;
            s2_valid_reg <= s1_valid_reg;
            s2_op_reg    <= s1_op_reg;
            if (item_fire && item.func == FN_FEATURE)
            begin
                last_reg  <= item.last;
                rowok_reg <= (item.row < in_dim_reg) && (32'(item.row) < MAX_IN);
            end
            if (state_reg == S_CBEG)
            begin
                colact_reg <= colact_now;
            end
        end
    end

    // Feature payload
    always_ff @(posedge clk)
    begin
        if (item_fire && item.func == FN_FEATURE)
        begin
            x_reg   <= item.value;
            row_reg <= item.row;
        end
    end

    // Rank value at the chain head, rounded to Q16.8 and saturated
    always_comb
    begin
        rq_wide  = (ACC_W+1)'($signed(rank_head)) + (ACC_W+1)'(128);
        rq_shift = rq_wide[ACC_W:8];
        if (rq_shift > (ACC_W-7)'(8388607))
        begin
            rq = RQ_W'(8388607);
        end
        else if (rq_shift < -(ACC_W-7)'(8388608))
        begin
            rq = -RQ_W'(8388608);
        end
        else
        begin
            rq = rq_shift[RQ_W-1:0];
        end
    end

    // Shared multiplier operands
    always_comb
    begin
        mult_a = MUL_AW'(x_reg);
        mult_b = MUL_BW'($signed(w_rdata));
        case (s1_op_reg)
            OP_W:
            begin
                mult_a = MUL_AW'(x_reg);
                mult_b = MUL_BW'($signed(w_rdata));
            end
            OP_A:
            begin
                mult_a = MUL_AW'(x_reg);
                mult_b = MUL_BW'($signed(a_rdata));
            end
            OP_B:
            begin
                mult_a = MUL_AW'(rq);
                mult_b = MUL_BW'($signed(b_rdata));
            end
            OP_SLO:
            begin
                mult_a = $signed({{(MUL_AW-SPLIT){1'b0}}, sum_reg[SPLIT-1:0]});
                mult_b = $signed({1'b0, scale_reg});
            end
            OP_SHI:
            begin
                mult_a = MUL_AW'($signed(sum_reg[SUMW-1:SPLIT]));
                mult_b = $signed({1'b0, scale_reg});
            end
            default: ;
        endcase
        mult_p = s1_en_reg ? PROD_W'(mult_a * mult_b) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_reg <= mult_p;
        end
    end

    // Chain updates
    always_comb
    begin
        out_upd  = sat_acc((ACC_W+3)'($signed(out_head)) + (ACC_W+3)'(prod_reg));
        rank_upd = sat_acc((ACC_W+3)'($signed(rank_head)) + (ACC_W+3)'(prod_reg));

        out_ctl.shift  = (s2_valid_reg && s2_op_reg == OP_W) || emit_fire;
        out_ctl.clr    = done_fire || (state_reg == S_FWAIT && !busy && last_reg
                                       && nout == '0);
        out_tail       = (s2_valid_reg && s2_op_reg == OP_W) ? out_upd : out_head;

        rank_ctl.shift = (s1_valid_reg && s1_op_reg == OP_B)
                         || (s2_valid_reg && s2_op_reg == OP_A);
        rank_ctl.clr   = out_ctl.clr;
        rank_tail      = (s2_valid_reg && s2_op_reg == OP_A) ? rank_upd : rank_head;
    end

    lrl_chain #(.N(MAX_OUT), .W(ACC_W)) u_out_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (out_ctl),
        .tail  (out_tail),
        .head  (out_head)
    );

    lrl_chain #(.N(MAX_RANK), .W(ACC_W)) u_rank_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rank_ctl),
        .tail  (rank_tail),
        .head  (rank_head)
    );

    // Adapter sum and scaled term
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CBEG)
        begin
            sum_reg <= '0;
        end
        else if (s2_valid_reg && s2_op_reg == OP_B)
        begin
            sum_reg <= sum_reg + SUMW'(prod_reg);
        end
        if (s2_valid_reg && s2_op_reg == OP_SLO)
        begin
            adp_reg <= ADPW'(prod_reg);
        end
        else if (s2_valid_reg && s2_op_reg == OP_SHI)
        begin
            adp_reg <= adp_reg + (ADPW'(prod_reg) <<< SPLIT);
        end
        if (state_reg == S_SUM)
        begin
            total_reg <= total_sum;
        end
    end

    // Column total in Q.16
    always_comb
    begin
        adp_round = (adp_reg + ADPW'(128)) >>> 8;
        total_sum = TOTW'($signed(out_head)) + TOTW'(adp_round);
        if (bias_en_reg)
        begin
            total_sum = total_sum + (TOTW'($signed(bias_rdata)) <<< 8);
        end
    end

    // Final rounding to Q8.8 with clipping
    always_comb
    begin
        y_wide = (total_reg + TOTW'(128)) >>> 8;
        y_clip = 1'b1;
        if (y_wide > TOTW'(32767))
        begin
            y_sat = 16'sh7FFF;
        end
        else if (y_wide < -TOTW'(32768))
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat  = y_wide[VAL_W-1:0];
            y_clip = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            res_index_reg <= IDX_W'(o_reg);
            res_value_reg <= y_sat;
            res_sat_reg   <= y_clip;
            res_last_reg  <= done_fire;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.out_index = res_index_reg;
    assign result.out_value = res_value_reg;
    assign result.saturated = res_sat_reg;
    assign result.out_last  = res_last_reg;

    lrl_ram #(.WIDTH(VAL_W), .DEPTH(WD)) u_w_ram (
        .clk(clk), .wr_en(w_wr_en), .wr_addr(w_wr_addr), .wr_data(item.value),
        .rd_en(w_rd_en), .rd_addr(w_rd_addr), .rd_data(w_rdata)
    );

    lrl_ram #(.WIDTH(VAL_W), .DEPTH(AD)) u_a_ram (
        .clk(clk), .wr_en(a_wr_en), .wr_addr(a_wr_addr), .wr_data(item.value),
        .rd_en(a_rd_en), .rd_addr(a_rd_addr), .rd_data(a_rdata)
    );

    lrl_ram #(.WIDTH(VAL_W), .DEPTH(BD)) u_b_ram (
        .clk(clk), .wr_en(b_wr_en), .wr_addr(b_wr_addr), .wr_data(item.value),
        .rd_en(b_rd_en), .rd_addr(b_rd_addr), .rd_data(b_rdata)
    );

    lrl_ram #(.WIDTH(VAL_W), .DEPTH(MAX_OUT)) u_bias_ram (
        .clk(clk), .wr_en(bias_wr_en), .wr_addr(bias_wr_addr), .wr_data(item.value),
        .rd_en(bias_rd_en), .rd_addr(bias_rd_addr), .rd_data(bias_rdata)
    );

`ifndef SYNTH
    // Items are only taken with the MAC pipeline empty
    assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("item taken while MAC pipeline busy");

    // The rank chain is never rotated by two pipeline stages at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !((s1_valid_reg && s1_op_reg == OP_B) && (s2_valid_reg && s2_op_reg == OP_A)))
        else $error("rank chain rotated twice in one cycle");

    // Nothing follows the final column beat straight away
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.out_last) |=> !result.valid)
        else $error("result beat after final column");
`endif

endmodule

// ----- rtl/lrl_ram.sv -----
module lrl_ram
    import lrl_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [addr_bits(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]            wr_data,
    input  logic                        rd_en,
    input  logic [addr_bits(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/lrl_cell.sv -----
module lrl_cell
    import lrl_pkg::*;
#(
    parameter int W = ACC_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  chain_ctl_t   ctl,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] value_reg;
    logic [W-1:0] value_next;

    // Clear wins over a shift
    always_comb
    begin
        value_next = value_reg;
        if (ctl.clr)
        begin
            value_next = '0;
        end
        else if (ctl.shift)
        begin
            value_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign dout = value_reg;

endmodule

// ----- rtl/lrl_chain.sv -----
module lrl_chain
    import lrl_pkg::*;
#(
    parameter int N = 16,
    parameter int W = ACC_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  chain_ctl_t   ctl,
    input  logic [W-1:0] tail,
    output logic [W-1:0] head
);

    // links[i] is the value of cell i; the updated head value enters at the tail
    logic [W-1:0] links [N+1];

    assign links[N] = tail;
    assign head     = links[0];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lrl_cell #(.W(W)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .din   (links[i+1]),
            .dout  (links[i])
        );
    end

endmodule
